### rtl/sdt_pkg.sv
`timescale 1ns / 1ps

package sdt_pkg;

   // Fixed field widths of the item and result channels.
   localparam int SYM_W       = 20;
   localparam int LEN_W       = 4;
   localparam int NUM_SYMBOLS = 10;
   localparam int IDX_W       = 7;
   localparam int TOTAL_W     = 8;
   localparam int TARGET_W    = 8;

   localparam int REQ_W = 24;
   localparam int RSP_W = 24;

   localparam logic [TARGET_W-1:0] TARGET_RESET = 8'd128;

   localparam int CAPACITY_DEFAULT   = 128;
   localparam int MAX_LENGTH_DEFAULT = 10;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   typedef struct packed {
      logic start;
      logic scan;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic scan_end;
      logic out_free;
   } status_type;

endpackage

### rtl/sdt_ram.sv
`timescale 1ns / 1ps

module sdt_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 128,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/sdt_ctrl.sv
`timescale 1ns / 1ps

module sdt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  sdt_pkg::status_type status,
   output sdt_pkg::cmd_type    cmd
);

   sdt_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         sdt_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = sdt_pkg::ST_SCAN;
            end
         end
         sdt_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.hit || status.scan_end) begin
               state_in = sdt_pkg::ST_DONE;
            end
         end
         sdt_pkg::ST_DONE: begin
            // Hold the verdict until the result register can take it.
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = sdt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sdt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sdt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/sdt_datapath.sv
`timescale 1ns / 1ps

module sdt_datapath #(
   parameter int CAPACITY   = sdt_pkg::CAPACITY_DEFAULT,
   parameter int MAX_LENGTH = sdt_pkg::MAX_LENGTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sdt_pkg::cmd_type              cmd,
   output sdt_pkg::status_type           status,
   input  logic [sdt_pkg::REQ_W-1:0]     req_tdata,
   input  logic                          csr_valid,
   input  logic [sdt_pkg::TARGET_W-1:0]  csr_data,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [sdt_pkg::RSP_W-1:0]     rsp_tdata
);

   localparam int CW    = $clog2(CAPACITY + 1);
   localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int KEY_W = sdt_pkg::LEN_W + sdt_pkg::SYM_W;

   logic [KEY_W-1:0]             key_ff;
   logic [CW-1:0]                count_ff, count_in;
   logic [CW-1:0]                scan_idx_ff;
   logic [AW-1:0]                cmp_idx_ff;
   logic                         cmp_valid_ff;
   logic                         found_ff;
   logic [AW-1:0]                found_idx_ff;
   logic [sdt_pkg::TARGET_W-1:0] target_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [sdt_pkg::RSP_W-1:0]    rsp_data_ff, rsp_data_in;

   logic [sdt_pkg::SYM_W-1:0]    in_sym;
   logic [sdt_pkg::LEN_W-1:0]    in_len;
   logic [sdt_pkg::SYM_W-1:0]    kept_sym;
   logic [sdt_pkg::LEN_W-1:0]    kept_len;
   logic                         issue;
   logic [KEY_W-1:0]             rd_data;
   logic                         hit;
   logic                         room;
   logic                         insert;
   logic [AW-1:0]                idx_sel;
   logic [31:0]                  idx_wide;
   logic [31:0]                  total_wide;

   assign in_sym = req_tdata[sdt_pkg::SYM_W-1:0];
   assign in_len = req_tdata[sdt_pkg::SYM_W +: sdt_pkg::LEN_W];

   // Saturate the length and clear the symbols beyond it, so that equal
   // sequences always give equal stored keys.
   always_comb begin
      kept_len = in_len;
      if (int'(in_len) > MAX_LENGTH) begin
         kept_len = sdt_pkg::LEN_W'(MAX_LENGTH);
      end
      kept_sym = '0;
      for (int i = 0; i < sdt_pkg::NUM_SYMBOLS; i++) begin
         if (i < int'(kept_len)) begin
            kept_sym[2*i +: 2] = in_sym[2*i +: 2];
         end
      end
   end

   assign issue = cmd.scan && (scan_idx_ff < count_ff);
   assign hit   = cmp_valid_ff && (rd_data == key_ff);

   assign room   = count_ff < CW'(CAPACITY);
   assign insert = !found_ff && room;

   sdt_ram #(
      .WIDTH (KEY_W),
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.finish && insert),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (key_ff),
      .rd_en   (issue),
      .rd_addr (scan_idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign status.hit      = hit;
   assign status.scan_end = !issue && !cmp_valid_ff;
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      count_in = count_ff;
      if (cmd.finish && insert) begin
         count_in = count_ff + CW'(1);
      end
      idx_sel = '0;
      if (found_ff) begin
         idx_sel = found_idx_ff;
      end else if (room) begin
         idx_sel = count_ff[AW-1:0];
      end
      idx_wide   = 32'(idx_sel);
      total_wide = 32'(count_in);
      rsp_data_in = '0;
      rsp_data_in[0]    = !found_ff;
      rsp_data_in[1]    = insert;
      rsp_data_in[8:2]  = idx_wide[sdt_pkg::IDX_W-1:0];
      rsp_data_in[16:9] = total_wide[sdt_pkg::TOTAL_W-1:0];
      rsp_data_in[17]   = !found_ff && !room;
      rsp_data_in[18]   = total_wide >= 32'(target_ff);
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         target_ff    <= sdt_pkg::TARGET_RESET;
         rsp_valid_ff <= 1'b0;
         cmp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         scan_idx_ff  <= '0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            target_ff <= csr_data;
         end
         if (cmd.start) begin
            scan_idx_ff  <= '0;
            cmp_valid_ff <= 1'b0;
            found_ff     <= 1'b0;
         end else if (cmd.scan) begin
            cmp_valid_ff <= issue;
            if (issue) begin
               scan_idx_ff <= scan_idx_ff + CW'(1);
            end
            if (hit) begin
               found_ff <= 1'b1;
            end
         end else begin
            cmp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         key_ff <= {kept_len, kept_sym};
      end
      if (issue) begin
         cmp_idx_ff <= scan_idx_ff[AW-1:0];
      end
      if (cmd.scan && hit) begin
         found_idx_ff <= cmp_idx_ff;
      end
      if (cmd.finish) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### rtl/sequence_dedup_table.sv
`timescale 1ns / 1ps

// Insert-if-absent table of short 2-bit symbol sequences.
// The req_ channel takes one sequence per item; the rsp_ channel returns
// one result item for each, in order. The csr_ channel writes the target
// count and is always ready; write it only while the block is idle.
// Each item is compared with the stored entries one per cycle through the
// single read port of the entry memory, lowest index first, stopping at the
// first match. One item is worked on at a time; req_tready is high only
// while the block waits for an item, from the cycle after the result is
// loaded at the earliest.
// A result waits in an output register while rsp_tready is low; the next
// item is accepted and scanned meanwhile and its result is held back until
// the register frees. Reset empties the table (the entry count goes to
// zero, no memory pass needed), sets the target count to 128 and drops any
// pending result.
module sequence_dedup_table #(
   parameter int CAPACITY   = sdt_pkg::CAPACITY_DEFAULT,
   parameter int MAX_LENGTH = sdt_pkg::MAX_LENGTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // Fields from bit 0: symbols[19:0], seq_length[23:20].
   input  logic [sdt_pkg::REQ_W-1:0]     req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // Fields from bit 0: is_unique[0], inserted[1], match_index[8:2],
   // stored_total[16:9], table_full[17], target_reached[18], zeros above.
   output logic [sdt_pkg::RSP_W-1:0]     rsp_tdata,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sdt_pkg::TARGET_W-1:0]  csr_data
);

   sdt_pkg::cmd_type    cmd;
   sdt_pkg::status_type status;

   assign csr_ready = 1'b1;

   sdt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sdt_datapath #(
      .CAPACITY   (CAPACITY),
      .MAX_LENGTH (MAX_LENGTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### rtl/sdt_checker.sv
`timescale 1ns / 1ps

module sdt_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [sdt_pkg::RSP_W-1:0]     rsp_tdata
);

   // A result offered and not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped before it was taken");

   // Only one item is in work at a time.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item accepted during a scan");

   // An inserted or dropped sequence must have been unique, never both.
   a_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[17] && rsp_tdata[1])
                     && !((rsp_tdata[17] || rsp_tdata[1]) && !rsp_tdata[0]))
      else $error("inconsistent result flags");

   // Reset leaves no result pending.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

endmodule

bind sequence_dedup_table sdt_checker u_checker (.*);
